>>> sv/pfh_pkg.sv
// Shared types and constants of the packet fragmenter.
`default_nettype none
package pfh_pkg;

  localparam int LEN_W   = 13;
  localparam int CHUNK_W = 9;

  localparam logic [CHUNK_W-1:0] PAYLOAD_MAX_RESET  = 9'd20;
  localparam logic [7:0]         HEADER_MAGIC_RESET = 8'd165;
  localparam logic [CHUNK_W-1:0] HDR_BYTES          = 9'd8;
  localparam logic [LEN_W-1:0]   FIRST_MAX          = 13'd255;

  // Register indexes on the configuration port (address bit 2).
  localparam logic REG_PAYLOAD_MAX  = 1'b0;
  localparam logic REG_HEADER_MAGIC = 1'b1;

  // Position of a beat within one header plus payload byte.
  localparam logic [3:0] STEP_MAGIC = 4'd0;
  localparam logic [3:0] STEP_SEQ0  = 4'd1;
  localparam logic [3:0] STEP_SEQ1  = 4'd2;
  localparam logic [3:0] STEP_SEQ2  = 4'd3;
  localparam logic [3:0] STEP_SEQ3  = 4'd4;
  localparam logic [3:0] STEP_INDEX = 4'd5;
  localparam logic [3:0] STEP_TOTAL = 4'd6;
  localparam logic [3:0] STEP_PLEN  = 4'd7;
  localparam logic [3:0] STEP_DATA  = 4'd8;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_CMD
  } front_state_t;

  // One command from the front to the back: an error beat, or one payload
  // byte optionally preceded by a fragment header.
  typedef struct packed {
    logic        err;
    logic        hdr;
    logic        last;
    logic [7:0]  data;
    logic [31:0] seq;
    logic [7:0]  index;
    logic [7:0]  total;
    logic [7:0]  plen;
  } cmd_t;

endpackage
`default_nettype wire

>>> sv/pfh_divider.sv
// Restoring divider that computes the fragment count, one quotient bit per cycle.
`default_nettype none
module pfh_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pfh_pkg::LEN_W-1:0]   dividend,
  input  wire logic [pfh_pkg::CHUNK_W-1:0] divisor,
  output logic                            done,
  output logic [pfh_pkg::LEN_W-1:0]        quotient
);
  import pfh_pkg::*;

  localparam logic [3:0] LastStep = 4'(LEN_W - 1);

  logic               busy;
  logic [3:0]         cnt;
  logic [CHUNK_W-1:0] rem;
  logic [LEN_W-1:0]   quo;
  logic [CHUNK_W-1:0] dvs;
  logic [CHUNK_W:0]   trial;
  logic [CHUNK_W:0]   diff;
  logic               ge;

  assign trial    = {rem, quo[LEN_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[CHUNK_W-1:0] : trial[CHUNK_W-1:0];
      quo <= {quo[LEN_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> sv/pfh_front.sv
// Front end: accepts packet bytes, tracks packet and fragment position, issues commands.
`default_nettype none
module pfh_front #(
  parameter int MAX_FRAGMENTS    = 16,
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [7:0]                  packet_byte,
  input  wire logic [pfh_pkg::LEN_W-1:0]   total_length,
  input  wire logic [31:0]                 sequence_number,
  input  wire logic [pfh_pkg::CHUNK_W-1:0] payload_max,
  output logic                            cmd_push,
  output pfh_pkg::cmd_t                   cmd,
  input  wire logic                       cmd_full
);
  import pfh_pkg::*;

  localparam logic [LEN_W:0] MaxFrag = (LEN_W+1)'(MAX_FRAGMENTS);
  localparam logic [16:0]    MaxPkt  = 17'(MAX_PACKET_BYTES);

  front_state_t       state, state_next;
  logic [LEN_W-1:0]   bytes_taken, bytes_taken_next;
  logic [LEN_W-1:0]   held_length, held_length_next;
  logic [31:0]        held_sequence, held_sequence_next;
  logic [CHUNK_W-1:0] chunk_size, chunk_size_next;
  logic [CHUNK_W-1:0] bytes_in_fragment, bytes_in_fragment_next;
  logic [7:0]         current_index, current_index_next;
  logic [7:0]         total_fragments, total_fragments_next;
  logic               dropping, dropping_next;
  logic               err_pending, err_pending_next;
  logic [7:0]         byte_hold, byte_hold_next;

  logic               div_start;
  logic               div_done;
  logic [LEN_W-1:0]   div_quotient;

  logic               do_payload;
  logic [7:0]         pay_byte;
  logic [LEN_W-1:0]   rem_len;
  logic [7:0]         plen;
  logic               last_pkt;
  logic               last_frag;
  logic               early_bad;
  logic [LEN_W:0]     count;
  logic [LEN_W-1:0]   first;
  logic [LEN_W-1:0]   taken_inc;

  pfh_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_length - 13'd1),
    .divisor  (payload_max - HDR_BYTES),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign full = (state != F_IDLE) || cmd_full;

  // Position of the current payload byte within packet and fragment.
  assign pay_byte  = (state == F_CMD) ? byte_hold : packet_byte;
  assign rem_len   = held_length - bytes_taken;
  assign plen      = (rem_len < {4'b0, chunk_size}) ? rem_len[7:0] : chunk_size[7:0];
  assign last_pkt  = ({1'b0, bytes_taken} + 14'd1) >= {1'b0, held_length};
  assign last_frag = last_pkt || (({1'b0, bytes_in_fragment} + 10'd1) >= {1'b0, chunk_size});
  assign taken_inc = bytes_taken + 13'd1;

  assign early_bad = (payload_max <= HDR_BYTES) || (total_length == '0) ||
                     ({4'b0, total_length} > MaxPkt);
  assign count     = {1'b0, div_quotient} + 14'd1;
  assign first     = (held_length < {4'b0, chunk_size}) ? held_length : {4'b0, chunk_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= F_IDLE;
      bytes_taken       <= '0;
      held_length       <= '0;
      held_sequence     <= '0;
      chunk_size        <= '0;
      bytes_in_fragment <= '0;
      current_index     <= '0;
      total_fragments   <= '0;
      dropping          <= 1'b0;
      err_pending       <= 1'b0;
    end else begin
      state             <= state_next;
      bytes_taken       <= bytes_taken_next;
      held_length       <= held_length_next;
      held_sequence     <= held_sequence_next;
      chunk_size        <= chunk_size_next;
      bytes_in_fragment <= bytes_in_fragment_next;
      current_index     <= current_index_next;
      total_fragments   <= total_fragments_next;
      dropping          <= dropping_next;
      err_pending       <= err_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_hold <= byte_hold_next;
  end

  always_comb begin
    state_next             = state;
    bytes_taken_next       = bytes_taken;
    held_length_next       = held_length;
    held_sequence_next     = held_sequence;
    chunk_size_next        = chunk_size;
    bytes_in_fragment_next = bytes_in_fragment;
    current_index_next     = current_index;
    total_fragments_next   = total_fragments;
    dropping_next          = dropping;
    err_pending_next       = err_pending;
    byte_hold_next         = byte_hold;
    div_start              = 1'b0;
    do_payload             = 1'b0;
    cmd_push               = 1'b0;

    cmd.err   = 1'b0;
    cmd.hdr   = (bytes_in_fragment == '0);
    cmd.last  = last_frag;
    cmd.data  = pay_byte;
    cmd.seq   = held_sequence;
    cmd.index = current_index;
    cmd.total = total_fragments;
    cmd.plen  = plen;

    unique case (state)
      F_IDLE: begin
        if (push && !cmd_full) begin
          byte_hold_next = packet_byte;
          if (bytes_taken == '0) begin
            held_length_next       = total_length;
            held_sequence_next     = sequence_number;
            bytes_in_fragment_next = '0;
            current_index_next     = '0;
            dropping_next          = 1'b0;
            if (early_bad) begin
              chunk_size_next      = '0;
              total_fragments_next = '0;
              err_pending_next     = 1'b1;
              state_next           = F_CMD;
            end else begin
              chunk_size_next = payload_max - HDR_BYTES;
              div_start       = 1'b1;
              state_next      = F_DIV;
            end
          end else if (dropping) begin
            bytes_taken_next = taken_inc;
            if (taken_inc >= held_length) begin
              bytes_taken_next = '0;
              dropping_next    = 1'b0;
            end
          end else begin
            do_payload = 1'b1;
          end
        end
      end
      F_DIV: begin
        if (div_done) begin
          if ((count > MaxFrag) || (first > FIRST_MAX)) begin
            total_fragments_next = '0;
            err_pending_next     = 1'b1;
          end else begin
            total_fragments_next = count[7:0];
            err_pending_next     = 1'b0;
          end
          state_next = F_CMD;
        end
      end
      F_CMD: begin
        if (!cmd_full) begin
          state_next = F_IDLE;
          if (err_pending) begin
            cmd_push         = 1'b1;
            cmd.err          = 1'b1;
            err_pending_next = 1'b0;
            bytes_taken_next = 13'd1;
            dropping_next    = 1'b1;
            if (held_length <= 13'd1) begin
              bytes_taken_next = '0;
              dropping_next    = 1'b0;
            end
          end else begin
            do_payload = 1'b1;
          end
        end
      end
      default: state_next = F_IDLE;
    endcase

    if (do_payload) begin
      cmd_push         = 1'b1;
      bytes_taken_next = taken_inc;
      if (last_pkt) begin
        bytes_taken_next       = '0;
        bytes_in_fragment_next = '0;
        current_index_next     = '0;
        dropping_next          = 1'b0;
      end else if (last_frag) begin
        bytes_in_fragment_next = '0;
        current_index_next     = current_index + 8'd1;
      end else begin
        bytes_in_fragment_next = bytes_in_fragment + 9'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/pfh_cmd_fifo.sv
// Two-entry command queue between the front and the back end.
`default_nettype none
module pfh_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pfh_pkg::cmd_t din,
  output logic               full,
  input  wire logic          pop,
  output pfh_pkg::cmd_t      dout,
  output logic               empty
);
  import pfh_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

>>> sv/pfh_back.sv
// Back end: turns commands into header, payload or error beats on the output register.
`default_nettype none
module pfh_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pfh_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire logic [7:0]    header_magic,
  output logic [7:0]         out_byte,
  output logic               fragment_end,
  output logic               packet_error,
  output logic               empty,
  input  wire logic          pop
);
  import pfh_pkg::*;

  logic       out_valid;
  logic [3:0] step;
  logic [3:0] eff_step;
  logic       issue;
  logic [7:0] beat_byte;
  logic       beat_end;

  assign empty    = !out_valid;
  assign issue    = !cmd_empty && (!out_valid || pop);
  assign eff_step = cmd.hdr ? step : STEP_DATA;
  assign cmd_pop  = issue && (cmd.err || (eff_step == STEP_DATA));
  assign beat_end = !cmd.err && (eff_step == STEP_DATA) && cmd.last;

  always_comb begin
    unique case (eff_step)
      STEP_MAGIC: beat_byte = header_magic;
      STEP_SEQ0:  beat_byte = cmd.seq[7:0];
      STEP_SEQ1:  beat_byte = cmd.seq[15:8];
      STEP_SEQ2:  beat_byte = cmd.seq[23:16];
      STEP_SEQ3:  beat_byte = cmd.seq[31:24];
      STEP_INDEX: beat_byte = cmd.index;
      STEP_TOTAL: beat_byte = cmd.total;
      STEP_PLEN:  beat_byte = cmd.plen;
      default:    beat_byte = cmd.data;
    endcase
    if (cmd.err) begin
      beat_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= STEP_MAGIC;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
        step      <= cmd_pop ? STEP_MAGIC : step + 4'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_byte     <= beat_byte;
      fragment_end <= beat_end;
      packet_error <= cmd.err;
    end
  end

endmodule
`default_nettype wire

>>> sv/packet_fragmenter_with_header.sv
// Top level of the packet fragmenter: configuration registers and the front/back pipeline.
//
// Input beats carry one packet byte each; total_length and sequence_number
// are sampled on the first byte of a packet only. A beat is taken when push
// is high and full is low. Output beats are the header and payload bytes of
// the fragments, taken when pop is high and empty is low.
// Every fragment starts with an 8-byte header: magic, sequence number in
// little-endian order, fragment index, fragment count and payload length.
// fragment_end marks the last payload byte of each fragment. A packet that
// cannot be fragmented gives one beat with packet_error set, and its
// remaining bytes are taken with no output.
// A packet's first byte keeps full high after it is taken while the
// fragment-count divider runs and until its first command is queued. A
// first byte refused before the divider keeps full high until its error
// command is queued. Every other byte is taken while the command queue
// has room, and its beats pass through the queue and the output register.
// The back end sends one beat per cycle while it has commands and pop is
// not held off, so a fragment of P payload bytes gives P + 8 output beats.
// Reset clears all packet state and the queue and loads payload_max = 20
// and header_magic = 165. When the receiver holds off pop, the output beat
// stays in place, the command queue fills, and full rises.
`default_nettype none
module packet_fragmenter_with_header #(
  parameter int MAX_FRAGMENTS    = 16,
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input beats
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  packet_byte,
  input  wire logic [12:0] total_length,
  input  wire logic [31:0] sequence_number,
  // Output beats
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             fragment_end,
  output logic             packet_error,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pfh_pkg::*;

  logic [CHUNK_W-1:0] payload_max;
  logic [7:0]         header_magic;
  logic               cfg_write;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;

  // Registers sit at byte addresses 0 and 4, so address bit 2 picks one.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_max  <= PAYLOAD_MAX_RESET;
      header_magic <= HEADER_MAGIC_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PAYLOAD_MAX:  payload_max  <= pwdata[CHUNK_W-1:0];
        REG_HEADER_MAGIC: header_magic <= pwdata[7:0];
        default:          payload_max  <= payload_max;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PAYLOAD_MAX:  prdata = {23'b0, payload_max};
      REG_HEADER_MAGIC: prdata = {24'b0, header_magic};
      default:          prdata = '0;
    endcase
  end

  // The front end tracks where each byte falls in its packet and fragment.
  pfh_front #(
    .MAX_FRAGMENTS    (MAX_FRAGMENTS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .packet_byte     (packet_byte),
    .total_length    (total_length),
    .sequence_number (sequence_number),
    .payload_max     (payload_max),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in),
    .cmd_full        (cmd_full)
  );

  pfh_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // The back end turns each command into one to nine output beats.
  pfh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_out),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .header_magic (header_magic),
    .out_byte     (out_byte),
    .fragment_end (fragment_end),
    .packet_error (packet_error),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
`default_nettype wire
